// ===== rtl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants for the prefix expression evaluator
// Item structs, status codes, symbol codes, ALU types and ALU and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package pee_pkg;
  localparam int StackDepth = 128;
  localparam int DataWidth  = 32;
  localparam int PtrW       = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int ExpCntW    = $clog2(DataWidth + 1);

  localparam logic [7:0] SymAdd = 8'h2B;
  localparam logic [7:0] SymSub = 8'h2D;
  localparam logic [7:0] SymMul = 8'h2A;
  localparam logic [7:0] SymDiv = 8'h2F;
  localparam logic [7:0] SymPow = 8'h24;
  localparam logic [7:0] SymZero = 8'h30;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StUnderflow = 3'd1;
  localparam logic [2:0] StFull      = 3'd2;
  localparam logic [2:0] StDivZero   = 3'd3;
  localparam logic [2:0] StZeroNeg   = 3'd4;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [7:0]         leftover;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ADD, OP_SUB, OP_DIV, OP_POW
  } alu_op_t;

  typedef struct packed {
    logic                 start;
    alu_op_t              op;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] result;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_POW_MUL, A_POW_SQR, A_DONE
  } alu_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_A, S_POP_B, S_WAIT_B, S_ALU, S_PUSH, S_READ_TOP, S_WAIT_TOP, S_EMIT
  } seq_state_t;
endpackage
`default_nettype wire

// ===== rtl/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu: shared iterative arithmetic unit
// Add and subtract directly; multiply, divide and power bit-serially.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_alu (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  logic          mul_sel,
  input  wire  pee_pkg::alu_req_t req,
  output pee_pkg::alu_rsp_t   rsp
);
  localparam int W = pee_pkg::DataWidth;

  pee_pkg::alu_state_t state, state_next;
  logic [W-1:0] acc, acc_next;     // product, quotient or power result
  logic [W-1:0] opx, opx_next;     // shifted multiplicand / dividend / base
  logic [W-1:0] opy, opy_next;     // multiplier bits / divisor / exponent
  logic [W-1:0] rem, rem_next;     // remainder, or running product
  logic [W-1:0] pw, pw_next;       // power: running result
  logic [pee_pkg::ExpCntW-1:0] cnt, cnt_next;
  logic neg, neg_next;
  logic [W:0] trial;
  logic [W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pee_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
    acc <= acc_next; opx <= opx_next; opy <= opy_next;
    rem <= rem_next; pw <= pw_next; cnt <= cnt_next; neg <= neg_next;
  end

  assign trial = {rem[W-2:0], opx[W-1]} - {1'b0, opy} + {1'b0, {W{1'b0}}};

  always_comb begin
    state_next = state;
    acc_next = acc; opx_next = opx; opy_next = opy;
    rem_next = rem; pw_next = pw; cnt_next = cnt; neg_next = neg;
    mplier = '0;
    rsp.done = 1'b0;
    rsp.result = acc;
    case (state)
      pee_pkg::A_IDLE: begin
        if (req.start) begin
          case (req.op)
            pee_pkg::OP_ADD: begin
              acc_next = req.a + req.b;
              state_next = pee_pkg::A_DONE;
            end
            pee_pkg::OP_SUB: begin
              acc_next = req.a - req.b;
              state_next = pee_pkg::A_DONE;
            end
            pee_pkg::OP_DIV: begin
              // mul_sel reuses the divide path slot for multiply
              if (mul_sel) begin
                acc_next = '0; opx_next = req.a; opy_next = req.b;
                cnt_next = pee_pkg::ExpCntW'(W);
                state_next = pee_pkg::A_MUL;
              end else begin
                neg_next = req.a[W-1] ^ req.b[W-1];
                opx_next = req.a[W-1] ? -req.a : req.a;
                opy_next = req.b[W-1] ? -req.b : req.b;
                rem_next = '0; acc_next = '0;
                cnt_next = pee_pkg::ExpCntW'(W);
                state_next = pee_pkg::A_DIV;
              end
            end
            default: begin
              opx_next = req.a; opy_next = req.b;
              pw_next = {{(W-1){1'b0}}, 1'b1};
              cnt_next = pee_pkg::ExpCntW'(W);
              state_next = pee_pkg::A_POW_MUL;
            end
          endcase
        end
      end
      pee_pkg::A_MUL: begin
        // shift-add, one multiplier bit a cycle
        if (opy[0]) acc_next = acc + opx;
        opx_next = opx << 1;
        opy_next = opy >> 1;
        cnt_next = cnt - 1'b1;
        if (cnt == pee_pkg::ExpCntW'(1)) state_next = pee_pkg::A_DONE;
      end
      pee_pkg::A_DIV: begin
        // restoring division, one quotient bit a cycle
        if (!trial[W]) begin
          rem_next = trial[W-1:0];
          acc_next = {acc[W-2:0], 1'b1};
        end else begin
          rem_next = {rem[W-2:0], opx[W-1]};
          acc_next = {acc[W-2:0], 1'b0};
        end
        opx_next = opx << 1;
        cnt_next = cnt - 1'b1;
        if (cnt == pee_pkg::ExpCntW'(1)) begin
          if (neg) acc_next = -acc_next;
          state_next = pee_pkg::A_DONE;
        end
      end
      pee_pkg::A_POW_MUL: begin
        // multiply result by base when exponent bit set: bit-serial product
        if (opy == '0) begin
          acc_next = pw;
          state_next = pee_pkg::A_DONE;
        end else if (opy[0]) begin
          mplier = opx;
          if (cnt == pee_pkg::ExpCntW'(W)) rem_next = '0;
          if (mplier[W - 32'(cnt)]) rem_next = (cnt == pee_pkg::ExpCntW'(W) ? '0 : rem)
              + (pw << (W - 32'(cnt)));
          cnt_next = cnt - 1'b1;
          if (cnt == pee_pkg::ExpCntW'(1)) begin
            pw_next = rem_next;
            cnt_next = pee_pkg::ExpCntW'(W);
            state_next = pee_pkg::A_POW_SQR;
          end
        end else begin
          state_next = pee_pkg::A_POW_SQR;
          cnt_next = pee_pkg::ExpCntW'(W);
        end
      end
      pee_pkg::A_POW_SQR: begin
        // square the base bit-serially
        if (cnt == pee_pkg::ExpCntW'(W)) rem_next = '0;
        if (opx[W - 32'(cnt)]) rem_next = (cnt == pee_pkg::ExpCntW'(W) ? '0 : rem)
            + (opx << (W - 32'(cnt)));
        cnt_next = cnt - 1'b1;
        if (cnt == pee_pkg::ExpCntW'(1)) begin
          opx_next = rem_next;
          opy_next = opy >> 1;
          cnt_next = pee_pkg::ExpCntW'(W);
          state_next = pee_pkg::A_POW_MUL;
        end
      end
      pee_pkg::A_DONE: begin
        rsp.done = 1'b1;
        state_next = pee_pkg::A_IDLE;
      end
      default: state_next = pee_pkg::A_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/pee_stack.sv =====
// ----------------------------------------------------------------------------
// pee_stack: operand stack memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_stack (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [pee_pkg::PtrW-1:0]         waddr,
  input  wire  [pee_pkg::DataWidth-1:0]    wdata,
  input  wire  [pee_pkg::PtrW-1:0]         raddr,
  output logic [pee_pkg::DataWidth-1:0]    rdata
);
  logic [pee_pkg::DataWidth-1:0] mem [pee_pkg::StackDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/prefix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_core: prefix expression evaluator
// Sequencer over an operand stack memory and one shared iterative ALU.
// ----------------------------------------------------------------------------
// Stall stays high after an accept while a digit is pushed, or while an operator
//   pops its operands, runs in the ALU (* and / one bit per cycle, $ a multiply
//   and a square per exponent bit, none on divide by zero or negative exponent)
//   and pushes; a final item adds a read of the top and any out_stall.
// Throughput: one item at a time; stall is high until the item is done.
// Reset: clears the stack count, the status and the sequencer and ALU state;
//   the operand registers and the stack memory itself are not cleared.
`default_nettype none
module prefix_expression_evaluator_core (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  pee_pkg::in_item_t    in_item,
  output logic                       out_valid,
  input  wire                        out_stall,
  output pee_pkg::out_item_t         out_item
);
  localparam int W = pee_pkg::DataWidth;

  pee_pkg::seq_state_t state, state_next;
  logic [pee_pkg::CntW-1:0] count, count_next;
  logic [2:0] err, err_next;
  logic [7:0] sym;
  logic fin;
  logic [W-1:0] opa, opa_next, res, res_next;
  logic a_ok, a_ok_next;

  logic we;
  logic [pee_pkg::PtrW-1:0] waddr, raddr;
  logic [W-1:0] wdata, rdata;
  pee_pkg::alu_req_t req;
  pee_pkg::alu_rsp_t rsp;
  logic mul_sel;
  logic is_op;

  pee_stack u_stack (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                     .raddr(raddr), .rdata(rdata));
  pee_alu u_alu (.clk(clk), .rst(rst), .mul_sel(mul_sel), .req(req), .rsp(rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pee_pkg::S_IDLE;
      count <= '0;
      err   <= pee_pkg::StOk;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
    if (state == pee_pkg::S_IDLE && in_valid) begin
      sym <= in_item.symbol;
      fin <= in_item.final_symbol;
    end
    opa <= opa_next; res <= res_next; a_ok <= a_ok_next;
  end

  assign is_op = sym == pee_pkg::SymAdd || sym == pee_pkg::SymSub ||
                 sym == pee_pkg::SymMul || sym == pee_pkg::SymDiv ||
                 sym == pee_pkg::SymPow;
  assign mul_sel = sym == pee_pkg::SymMul;
  assign in_stall = state != pee_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    count_next = count; err_next = err;
    opa_next = opa; res_next = res; a_ok_next = a_ok;
    we = 1'b0;
    waddr = count[pee_pkg::PtrW-1:0];
    wdata = res;
    raddr = count[pee_pkg::PtrW-1:0] - 1'b1;
    req = '0;
    out_valid = 1'b0;
    out_item.value    = 32'(signed'(res));
    out_item.status   = err;
    out_item.leftover = (count == '0) ? 8'd0 : 8'(count - 1'b1);
    case (state)
      pee_pkg::S_IDLE: begin
        if (in_valid) state_next = pee_pkg::S_POP_A;
      end
      pee_pkg::S_POP_A: begin
        if (!is_op) begin
          res_next = W'(sym) - W'(pee_pkg::SymZero);
          state_next = pee_pkg::S_PUSH;
        end else begin
          // read issued at count-1; data lands next cycle
          if (count == '0) begin
            if (err_next == pee_pkg::StOk) err_next = pee_pkg::StUnderflow;
            a_ok_next = 1'b0;
          end else begin
            a_ok_next = 1'b1;
            count_next = count - 1'b1;
          end
          state_next = pee_pkg::S_POP_B;
        end
      end
      pee_pkg::S_POP_B: begin
        opa_next = a_ok ? rdata : '0;
        if (count == '0) begin
          if (err_next == pee_pkg::StOk) err_next = pee_pkg::StUnderflow;
          a_ok_next = 1'b0;
        end else begin
          a_ok_next = 1'b1;
          count_next = count - 1'b1;
        end
        state_next = pee_pkg::S_WAIT_B;
      end
      pee_pkg::S_WAIT_B: begin
        state_next = pee_pkg::S_ALU;
        req.start = 1'b1;
        req.a = opa;
        req.b = a_ok ? rdata : '0;
        case (sym)
          pee_pkg::SymAdd: req.op = pee_pkg::OP_ADD;
          pee_pkg::SymSub: req.op = pee_pkg::OP_SUB;
          pee_pkg::SymPow: req.op = pee_pkg::OP_POW;
          default:         req.op = pee_pkg::OP_DIV;
        endcase
        // special cases handled without the ALU
        if (sym == pee_pkg::SymDiv && req.b == '0) begin
          req.start = 1'b0;
          if (err == pee_pkg::StOk) err_next = pee_pkg::StDivZero;
          res_next = '0;
          state_next = pee_pkg::S_PUSH;
        end else if (sym == pee_pkg::SymPow && req.b[W-1]) begin
          req.start = 1'b0;
          if (opa == W'(1)) res_next = W'(1);
          else if (opa == '1) res_next = req.b[0] ? '1 : W'(1);
          else begin
            res_next = '0;
            if (opa == '0 && err == pee_pkg::StOk) err_next = pee_pkg::StZeroNeg;
          end
          state_next = pee_pkg::S_PUSH;
        end
      end
      pee_pkg::S_ALU: begin
        if (rsp.done) begin
          res_next = rsp.result;
          state_next = pee_pkg::S_PUSH;
        end
      end
      pee_pkg::S_PUSH: begin
        if (count >= pee_pkg::CntW'(pee_pkg::StackDepth)) begin
          if (err == pee_pkg::StOk) err_next = pee_pkg::StFull;
        end else begin
          we = 1'b1;
          count_next = count + 1'b1;
        end
        state_next = fin ? pee_pkg::S_READ_TOP : pee_pkg::S_IDLE;
      end
      pee_pkg::S_READ_TOP: begin
        state_next = pee_pkg::S_WAIT_TOP;
      end
      pee_pkg::S_WAIT_TOP: begin
        if (count == '0) begin
          res_next = '0;
          if (err == pee_pkg::StOk) err_next = pee_pkg::StUnderflow;
        end else begin
          res_next = rdata;
        end
        state_next = pee_pkg::S_EMIT;
      end
      pee_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          count_next = '0;
          err_next = pee_pkg::StOk;
          state_next = pee_pkg::S_IDLE;
        end
      end
      default: state_next = pee_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== test/prefix_expression_evaluator_core_tb.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_core_tb: self-checking bench for the evaluator
// Feeds prefix expressions (right to left) through the valid/stall input,
// predicts each result with a local stack calculator and checks every output
// item field by field. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module prefix_expression_evaluator_core_tb;

  localparam int WatchdogLimit = 40000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pee_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pee_pkg::out_item_t out_item;

  prefix_expression_evaluator_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be driven and results waiting to be seen.
  pee_pkg::in_item_t  symbols_pending[$];
  pee_pkg::out_item_t results_due[$];

  // Local copy of the operand stack, its depth and the sticky status.
  logic [31:0] calc_stack[pee_pkg::StackDepth];
  int          calc_depth;
  logic [2:0]  calc_status;

  int items_taken, results_seen, mismatches, error_results;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic bit is_operator(logic [7:0] s);
    return s == pee_pkg::SymAdd || s == pee_pkg::SymSub || s == pee_pkg::SymMul ||
           s == pee_pkg::SymDiv || s == pee_pkg::SymPow;
  endfunction

  // Keep only the first error until the result is emitted.
  function automatic void raise_status(logic [2:0] code);
    if (calc_status == pee_pkg::StOk) calc_status = code;
  endfunction

  function automatic logic [31:0] pop_operand();
    if (calc_depth == 0) begin
      raise_status(pee_pkg::StUnderflow);
      return '0;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  function automatic void push_operand(logic [31:0] v);
    if (calc_depth >= pee_pkg::StackDepth) begin
      raise_status(pee_pkg::StFull);
      return;
    end
    calc_stack[calc_depth] = v;
    calc_depth++;
  endfunction

  // Truncate toward zero; most negative / -1 wraps back to most negative.
  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] mag_a, mag_b, q;
    if (b == 0) begin
      raise_status(pee_pkg::StDivZero);
      return '0;
    end
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    q = mag_a / mag_b;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // Square and multiply, wrapping; negative exponents only survive for +/-1.
  function automatic logic [31:0] raise_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc, sq;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == '1) return ex[0] ? '1 : 32'd1;
      if (base == 0) raise_status(pee_pkg::StZeroNeg);
      return '0;
    end
    acc = 32'd1;
    sq  = base;
    for (int i = 0; i < 32; i++) begin
      if (ex[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  task automatic evaluate_symbol(input pee_pkg::in_item_t it);
    logic [31:0]        lhs, rhs, res;
    pee_pkg::out_item_t r;
    if (is_operator(it.symbol)) begin
      lhs = pop_operand();
      rhs = pop_operand();
      case (it.symbol)
        pee_pkg::SymAdd: res = lhs + rhs;
        pee_pkg::SymSub: res = lhs - rhs;
        pee_pkg::SymMul: res = lhs * rhs;
        pee_pkg::SymDiv: res = quotient(lhs, rhs);
        default:         res = raise_power(lhs, rhs);
      endcase
      push_operand(res);
    end else begin
      push_operand({24'd0, it.symbol} - {24'd0, pee_pkg::SymZero});
    end
    if (!it.final_symbol) return;
    if (calc_depth == 0) begin
      raise_status(pee_pkg::StUnderflow);
      r.value    = '0;
      r.leftover = '0;
    end else begin
      r.value    = calc_stack[calc_depth - 1];
      r.leftover = 8'(calc_depth - 1);
    end
    r.status = calc_status;
    results_due.push_back(r);
    calc_depth  = 0;
    calc_status = pee_pkg::StOk;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_symbol(input logic [7:0] s, input bit last);
    pee_pkg::in_item_t it;
    it.symbol       = s;
    it.final_symbol = last;
    symbols_pending.push_back(it);
  endtask

  function automatic logic [7:0] random_operand();
    logic [7:0] s;
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(48, 57));
    do s = 8'($urandom); while (is_operator(s));
    return s;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4:    return pee_pkg::SymAdd;
      5, 6, 7, 8, 9:    return pee_pkg::SymSub;
      10, 11, 12, 13:   return pee_pkg::SymMul;
      14, 15, 16, 17:   return pee_pkg::SymDiv;
      default:          return pee_pkg::SymPow;
    endcase
  endfunction

  // Well-formed expression: operands and operators in feed order, closed so
  // that exactly one entry remains after the leftmost symbol.
  task automatic queue_expression(input int body_len);
    int depth;
    depth = 0;
    for (int i = 0; i < body_len; i++) begin
      if (depth >= 2 && $urandom_range(0, 2) == 0) begin
        queue_symbol(random_operator(), 1'b0);
        depth--;
      end else begin
        queue_symbol(random_operand(), 1'b0);
        depth++;
      end
    end
    if (depth == 0) begin
      queue_symbol(random_operand(), 1'b1);
      return;
    end
    if (depth == 1) begin
      queue_symbol(random_operand(), 1'b0);
      depth++;
    end
    while (depth > 2) begin
      queue_symbol(random_operator(), 1'b0);
      depth--;
    end
    queue_symbol(random_operator(), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of items separated by random gaps; hold while stalled.
  // ---------------------------------------------------------------------------
  int burst_left, gap_left;

  always @(posedge clk) begin : drive_symbols
    bit took;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 4;
      gap_left   <= 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        evaluate_symbol(in_item);
        void'(symbols_pending.pop_front());
        items_taken++;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (symbols_pending.size() > 0) begin
          in_valid <= 1'b1;
          in_item  <= symbols_pending[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stall pattern changes mode after a random run.
  // ---------------------------------------------------------------------------
  int stall_mode, mode_left;

  always @(posedge clk) begin : check_results
    pee_pkg::out_item_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 300;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_item.status != pee_pkg::StOk) error_results++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value=%0d status=%0d leftover=%0d",
                     out_item.value, out_item.status, out_item.leftover);
        end else begin
          want = results_due.pop_front();
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected value=%0d status=%0d leftover=%0d,",
                        " got value=%0d status=%0d leftover=%0d"},
                       results_seen, want.value, want.status, want.leftover,
                       out_item.value, out_item.status, out_item.leftover);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(100, 600);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 4);
        default: out_stall <= ($urandom_range(0, 19) < 17);
      endcase
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no item accepted for %0d cycles", WatchdogLimit);
      $display("prefix_expression_evaluator_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed cases, random expressions, then drain.
  // ---------------------------------------------------------------------------
  initial begin
    calc_depth  = 0;
    calc_status = pee_pkg::StOk;
    // Extremes of the symbol byte.
    queue_symbol(8'h00, 1'b1);
    queue_symbol(8'hFF, 1'b1);
    // Add, subtract and multiply: right operand fed first.
    queue_symbol("3", 1'b0); queue_symbol("7", 1'b0); queue_symbol(pee_pkg::SymAdd, 1'b1);
    queue_symbol("9", 1'b0); queue_symbol("2", 1'b0); queue_symbol(pee_pkg::SymSub, 1'b1);
    queue_symbol("6", 1'b0); queue_symbol("8", 1'b0); queue_symbol(pee_pkg::SymMul, 1'b1);
    // Divide by zero.
    queue_symbol("0", 1'b0); queue_symbol("5", 1'b0); queue_symbol(pee_pkg::SymDiv, 1'b1);
    // Most negative divided by -1: (2 $ 31) / (0 - 1).
    queue_symbol("1", 1'b0); queue_symbol("0", 1'b0); queue_symbol(pee_pkg::SymSub, 1'b0);
    queue_symbol(8'h4F, 1'b0); queue_symbol("2", 1'b0); queue_symbol(pee_pkg::SymPow, 1'b0);
    queue_symbol(pee_pkg::SymDiv, 1'b1);
    // Zero and one to a negative power.
    queue_symbol(8'h00, 1'b0); queue_symbol("0", 1'b0); queue_symbol(pee_pkg::SymPow, 1'b1);
    queue_symbol(8'h00, 1'b0); queue_symbol("1", 1'b0); queue_symbol(pee_pkg::SymPow, 1'b1);
    // Missing operands.
    queue_symbol(pee_pkg::SymAdd, 1'b1);

    // Minus one to an odd negative power (exponent -7), then a full stack.
    queue_symbol(8'h29, 1'b0);
    queue_symbol("1", 1'b0); queue_symbol("0", 1'b0); queue_symbol(pee_pkg::SymSub, 1'b0);
    queue_symbol(pee_pkg::SymPow, 1'b1);
    for (int i = 0; i < pee_pkg::StackDepth + 2; i++) queue_symbol(random_operand(), 1'b0);
    queue_symbol("4", 1'b1);

    // Random part: mostly well-formed expressions, some loose noise.
    while (symbols_pending.size() < 470) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_expression($urandom_range(0, 12));
      end else begin
        repeat ($urandom_range(1, 6))
          queue_symbol(8'($urandom), ($urandom_range(0, 3) == 0));
        queue_symbol(8'($urandom), 1'b1);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (symbols_pending.size() > 0 || in_valid || results_due.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);

    $display("ran %0d symbols through the evaluator, checked %0d results",
             items_taken, results_seen);
    $display("%0d results carried an error status, %0d mismatches",
             error_results, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("prefix_expression_evaluator_core_tb: PASS");
    end else begin
      $display("prefix_expression_evaluator_core_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
